/* rtl/rtsp_pkg.sv */
// ----------------------------------------------------------------------------
// rtsp_pkg: shared types and constants of the render target slot pool
// Status codes, action codes, field widths and the descriptor layout.
// ----------------------------------------------------------------------------
package rtsp_pkg;

	localparam int SLOTS_DEFAULT = 64;
	localparam int SLOT_W = 6;
	localparam int LIVE_W = 7;
	localparam int FMT_W = 31;
	localparam int CAPS_W = 16;
	localparam int DIM_W = 16;
	localparam int AGE_W = 2;

	localparam logic [1:0] ACT_ACQUIRE = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	localparam logic [2:0] ST_REUSED = 3'd0;
	localparam logic [2:0] ST_NEW = 3'd1;
	localparam logic [2:0] ST_RELEASED = 3'd2;
	localparam logic [2:0] ST_DESTROYED = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;
	localparam logic [2:0] ST_BAD = 3'd6;

	localparam logic [AGE_W-1:0] AGE_FRESH = 2'd3;

	// Descriptor held in the slot memory.
	typedef struct packed {
		logic              kind;
		logic [FMT_W-1:0]  format;
		logic [CAPS_W-1:0] caps;
		logic [DIM_W-1:0]  height;
		logic [DIM_W-1:0]  width;
	} desc_t;

	// One result item.
	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [LIVE_W-1:0] live_count;
		logic              last;
	} result_t;

endpackage

/* rtl/rtsp_desc_mem.sv */
// ----------------------------------------------------------------------------
// rtsp_desc_mem: descriptor and age memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rtsp_desc_mem #(
	parameter int SLOTS = rtsp_pkg::SLOTS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(SLOTS)-1:0]         wr_addr,
	input  rtsp_pkg::desc_t                  wr_desc,
	input  logic [rtsp_pkg::AGE_W-1:0]       wr_age,
	input  logic [$clog2(SLOTS)-1:0]         rd_addr,
	output rtsp_pkg::desc_t                  rd_desc,
	output logic [rtsp_pkg::AGE_W-1:0]       rd_age
);

	rtsp_pkg::desc_t              desc_mem [SLOTS];
	logic [rtsp_pkg::AGE_W-1:0]   age_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			desc_mem[wr_addr] <= wr_desc;
			age_mem[wr_addr] <= wr_age;
		end
		rd_desc <= desc_mem[rd_addr];
		rd_age <= age_mem[rd_addr];
	end

endmodule

/* rtl/render_target_slot_pool_core.sv */
// A zero-size acquire or an unknown action is answered from the result register alone,
// a release after the S_EMIT state. Acquire reads one slot per cycle from the descriptor memory
// and answers with the lowest matching slot, or after the whole scan without one.
// Flush walks every slot, gives its first result once the walk is over and
// then one result per cycle while the output is not stalled. One item at a time.
// Reset (arst_n low) empties every slot and clears default_caps; the memories keep contents.
// ----------------------------------------------------------------------------
// render_target_slot_pool_core: pool of render target descriptors
// Acquire, release and flush over a memory of slot descriptors.
// ----------------------------------------------------------------------------
module render_target_slot_pool_core #(
	parameter int SLOTS = rtsp_pkg::SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: default_caps
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// Input: action[1:0], kind[2], format[33:3], caps[49:34], width[65:50],
	// height[81:66], target_slot[87:82], zeros above
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,
	// Output: status[2:0], slot[8:3], live_count[15:9]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW:0] SLOTS_C = (IW+1)'(SLOTS);

	// Control states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_FLUSH = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_DEST = 3'd4;

	logic [2:0]              state_q;
	logic [SLOTS-1:0]        empty_q, avail_q;
	logic [15:0]             dcaps_q;
	logic [IW:0]             live_q;
	logic [87:0]             req_q;
	logic [IW:0]             idx_q;     // address issued to memory
	logic                    rd_vld_s1; // memory data valid this cycle
	logic [IW-1:0]           rd_idx_s1;
	// Slots emptied by the running flush; reported once the walk is over, so
	// that every destruction result carries the final live count.
	logic [SLOTS-1:0]        gone_q;
	// Result register and the value loaded into it.
	rtsp_pkg::result_t       res_q;
	logic                    res_vld_q;
	rtsp_pkg::result_t       res_d;
	logic                    res_load;

	wire        r_kind = req_q[2];
	wire [30:0] r_format = req_q[33:3];
	wire [15:0] r_caps = req_q[49:34];
	wire [15:0] r_width = req_q[65:50];
	wire [15:0] r_height = req_q[81:66];
	wire [5:0]  r_target = req_q[87:82];

	logic                       mem_we;
	logic [IW-1:0]              mem_waddr;
	rtsp_pkg::desc_t            mem_wdesc, rd_desc;
	logic [rtsp_pkg::AGE_W-1:0] mem_wage, rd_age;

	rtsp_desc_mem #(.SLOTS(SLOTS)) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_desc (mem_wdesc),
		.wr_age  (mem_wage),
		.rd_addr (idx_q[IW-1:0]),
		.rd_desc (rd_desc),
		.rd_age  (rd_age)
	);

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE) && !res_vld_q;
	assign m_axis_tvalid = res_vld_q;
	assign m_axis_tdata = {res_q.live_count[6:0] & 7'h7f, res_q.slot, res_q.status};
	assign m_axis_tlast = res_q.last;

	// Lowest empty slot, the target of a fresh record.
	logic [IW-1:0] first_empty;
	logic          any_empty;
	always_comb begin
		first_empty = '0;
		any_empty = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (empty_q[i]) begin
				first_empty = IW'(i);
				any_empty = 1'b1;
			end
		end
	end

	// Lowest slot still to be reported as destroyed, and the set left after it.
	logic [IW-1:0] gone_first;
	always_comb begin
		gone_first = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (gone_q[i]) gone_first = IW'(i);
		end
	end
	wire [SLOTS-1:0] gone_rest = gone_q & (gone_q - SLOTS'(1));
	wire             gone_more = |gone_rest;

	// Match test on the slot just read.
	wire rd_match = avail_q[rd_idx_s1] && rd_desc.kind == r_kind
		&& rd_desc.format == r_format && rd_desc.width == r_width
		&& rd_desc.height == r_height && ((rd_desc.caps & r_caps) == r_caps);
	wire rd_aged = !empty_q[rd_idx_s1] && avail_q[rd_idx_s1];

	wire out_free = !res_vld_q || m_axis_tready;
	wire [5:0] tgt6 = r_target;
	wire [IW-1:0] tgt = tgt6[IW-1:0];
	wire tgt_bad = ({1'b0, tgt6} >= 7'(SLOTS)) || empty_q[tgt] || avail_q[tgt];

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdesc = rd_desc;
		mem_wage = rtsp_pkg::AGE_FRESH;
		if (state_q == S_SCAN && rd_vld_s1 && rd_match) begin
			mem_we = 1'b1;
		end else if (state_q == S_SCAN && rd_vld_s1 && idx_q == SLOTS_C && any_empty) begin
			// Scan ended without a match: record in the lowest empty slot.
			mem_we = 1'b1;
			mem_waddr = first_empty;
			mem_wdesc.kind = r_kind;
			mem_wdesc.format = r_format;
			mem_wdesc.caps = r_caps | dcaps_q;
			mem_wdesc.width = r_width;
			mem_wdesc.height = r_height;
		end else if (state_q == S_FLUSH && rd_vld_s1 && rd_aged) begin
			mem_we = 1'b1;
			mem_wage = (rd_age > 2'd1) ? rd_age - 2'd1 : 2'd0;
		end
	end

	// Result selection: which result enters the output register this cycle.
	always_comb begin
		res_load = 1'b0;
		res_d = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					unique case (s_axis_tdata[1:0])
						rtsp_pkg::ACT_ACQUIRE: begin
							// A zero width or height is refused at once.
							if (s_axis_tdata[65:50] == '0 || s_axis_tdata[81:66] == '0) begin
								res_d = '{rtsp_pkg::ST_BAD, '0, 7'(live_q), 1'b1};
								res_load = 1'b1;
							end
						end
						rtsp_pkg::ACT_RELEASE, rtsp_pkg::ACT_FLUSH: ;
						default: begin
							res_d = '{rtsp_pkg::ST_BAD, '0, 7'(live_q), 1'b1};
							res_load = 1'b1;
						end
					endcase
				end
			end
			S_EMIT: begin
				if (tgt_bad) begin
					res_d = '{rtsp_pkg::ST_BAD, tgt6, 7'(live_q), 1'b1};
				end else begin
					res_d = '{rtsp_pkg::ST_RELEASED, tgt6, 7'(live_q), 1'b1};
				end
				res_load = 1'b1;
			end
			S_SCAN: begin
				if (rd_vld_s1 && rd_match) begin
					res_d = '{rtsp_pkg::ST_REUSED, 6'(rd_idx_s1), 7'(live_q), 1'b1};
					res_load = 1'b1;
				end else if (rd_vld_s1 && idx_q == SLOTS_C) begin
					if (any_empty) begin
						res_d = '{rtsp_pkg::ST_NEW, 6'(first_empty), 7'(live_q + 1'b1), 1'b1};
					end else begin
						res_d = '{rtsp_pkg::ST_FULL, '0, 7'(live_q), 1'b1};
					end
					res_load = 1'b1;
				end
			end
			S_FLUSH: ;
			S_DEST: begin
				// One destruction per cycle while the output is free, lowest slot
				// first; a flush that emptied nothing answers with a single done result.
				if (out_free) begin
					if (|gone_q) begin
						res_d = '{rtsp_pkg::ST_DESTROYED, 6'(gone_first), 7'(live_q),
							!gone_more};
					end else begin
						res_d = '{rtsp_pkg::ST_DONE, '0, 7'(live_q), 1'b1};
					end
					res_load = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			empty_q <= '1;
			avail_q <= '0;
			dcaps_q <= '0;
			live_q <= '0;
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			gone_q <= '0;
			res_vld_q <= 1'b0;
			res_q <= '0;
			req_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) dcaps_q <= cfg_data;
			res_vld_q <= res_load || (res_vld_q && !m_axis_tready);
			if (res_load) res_q <= res_d;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						req_q <= s_axis_tdata;
						idx_q <= '0;
						rd_vld_s1 <= 1'b0;
						unique case (s_axis_tdata[1:0])
							rtsp_pkg::ACT_ACQUIRE: begin
								if (s_axis_tdata[65:50] != '0 && s_axis_tdata[81:66] != '0)
									state_q <= S_SCAN;
							end
							rtsp_pkg::ACT_RELEASE: state_q <= S_EMIT;
							rtsp_pkg::ACT_FLUSH: state_q <= S_FLUSH;
							default: ;
						endcase
					end
				end
				S_EMIT: begin
					// Release decision, in the cycle after capture.
					if (!tgt_bad) avail_q[tgt] <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					// Issue addresses 0..SLOTS-1; evaluate each in the cycle after.
					if (idx_q < SLOTS_C) begin
						rd_idx_s1 <= idx_q[IW-1:0];
						idx_q <= idx_q + 1'b1;
					end
					if (rd_vld_s1 && rd_match) begin
						avail_q[rd_idx_s1] <= 1'b0;
						rd_vld_s1 <= 1'b0;
						state_q <= S_IDLE;
					end else if (rd_vld_s1 && idx_q == SLOTS_C) begin
						// Last slot evaluated with no match.
						if (any_empty) begin
							empty_q[first_empty] <= 1'b0;
							live_q <= live_q + 1'b1;
						end
						rd_vld_s1 <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						rd_vld_s1 <= (idx_q < SLOTS_C);
					end
				end
				S_FLUSH: begin
					// Walk every slot without pausing; emptied slots are
					// collected in gone_q and reported afterwards.
					if (idx_q < SLOTS_C) begin
						rd_idx_s1 <= idx_q[IW-1:0];
						idx_q <= idx_q + 1'b1;
					end
					rd_vld_s1 <= (idx_q < SLOTS_C);
					if (rd_vld_s1 && rd_aged && rd_age <= 2'd1) begin
						empty_q[rd_idx_s1] <= 1'b1;
						avail_q[rd_idx_s1] <= 1'b0;
						gone_q[rd_idx_s1] <= 1'b1;
						live_q <= live_q - 1'b1;
					end
					if (!rd_vld_s1 && idx_q == SLOTS_C) state_q <= S_DEST;
				end
				S_DEST: begin
					if (out_free) begin
						gone_q <= gone_rest;
						if (!gone_more) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* dv/render_target_slot_pool_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// render_target_slot_pool_core_tb: self-checking bench for the slot pool
// A pool model predicts every acquire, release and flush result; a monitor
// compares each output transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
module render_target_slot_pool_core_tb;

	localparam int NSLOT = 64;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;

	render_target_slot_pool_core #(.SLOTS(NSLOT)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Pool model state.
	logic [63:0]                 pm_empty;
	logic [63:0]                 pm_avail;
	logic [1:0]                  pm_age [NSLOT];
	rtsp_pkg::desc_t             pm_desc [NSLOT];
	logic [rtsp_pkg::CAPS_W-1:0] pm_default_caps;

	rtsp_pkg::result_t expected_results[$];
	logic [87:0]       pending_requests[$];
	int                errors;
	int                results_seen;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                idle_cycles;
	logic              in_taken;

	function automatic logic [rtsp_pkg::LIVE_W-1:0] live_slots();
		logic [rtsp_pkg::LIVE_W-1:0] n;
		n = 0;
		for (int i = 0; i < NSLOT; i++) n += !pm_empty[i];
		return n;
	endfunction

	task automatic push_result(input logic [2:0] st, input logic [rtsp_pkg::SLOT_W-1:0] sl,
			input logic lst);
		rtsp_pkg::result_t r;
		r.status = st;
		r.slot = sl;
		r.live_count = live_slots();
		r.last = lst;
		expected_results.push_back(r);
	endtask

	// Applies one request to the pool model and queues its results.
	task automatic predict_pool_step(input logic [87:0] d);
		logic [1:0]                  act;
		logic                        knd;
		logic [rtsp_pkg::FMT_W-1:0]  fmt;
		logic [rtsp_pkg::CAPS_W-1:0] cp;
		logic [rtsp_pkg::DIM_W-1:0]  w, h;
		logic [rtsp_pkg::SLOT_W-1:0] t;
		int                          gone[$];
		bit                          done;
		act = d[1:0]; knd = d[2]; fmt = d[33:3]; cp = d[49:34];
		w = d[65:50]; h = d[81:66]; t = d[87:82];
		done = 0;
		case (act)
			rtsp_pkg::ACT_ACQUIRE: begin
				if (w == 0 || h == 0) begin
					push_result(rtsp_pkg::ST_BAD, '0, 1'b1);
				end else begin
					for (int i = 0; i < NSLOT && !done; i++) begin
						if (pm_avail[i] && pm_desc[i].kind == knd && pm_desc[i].format == fmt
								&& pm_desc[i].width == w && pm_desc[i].height == h
								&& (pm_desc[i].caps & cp) == cp) begin
							pm_age[i] = rtsp_pkg::AGE_FRESH;
							pm_avail[i] = 0;
							push_result(rtsp_pkg::ST_REUSED, 6'(i), 1'b1);
							done = 1;
						end
					end
					for (int i = 0; i < NSLOT && !done; i++) begin
						if (pm_empty[i]) begin
							pm_empty[i] = 0;
							pm_avail[i] = 0;
							pm_desc[i].kind = knd;
							pm_desc[i].format = fmt;
							pm_desc[i].caps = cp | pm_default_caps;
							pm_desc[i].width = w;
							pm_desc[i].height = h;
							pm_age[i] = rtsp_pkg::AGE_FRESH;
							push_result(rtsp_pkg::ST_NEW, 6'(i), 1'b1);
							done = 1;
						end
					end
					if (!done) push_result(rtsp_pkg::ST_FULL, '0, 1'b1);
				end
			end
			rtsp_pkg::ACT_RELEASE: begin
				if (pm_empty[t] || pm_avail[t]) begin
					push_result(rtsp_pkg::ST_BAD, t, 1'b1);
				end else begin
					pm_avail[t] = 1;
					push_result(rtsp_pkg::ST_RELEASED, t, 1'b1);
				end
			end
			rtsp_pkg::ACT_FLUSH: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (!pm_empty[i] && pm_avail[i]) begin
						if (pm_age[i] > 1) begin
							pm_age[i] = 2'(pm_age[i] - 1);
						end else begin
							pm_age[i] = 0;
							pm_empty[i] = 1;
							pm_avail[i] = 0;
							gone.push_back(i);
						end
					end
				end
				if (gone.size() == 0) push_result(rtsp_pkg::ST_DONE, '0, 1'b1);
				// Live count reflects the state after the whole flush.
				foreach (gone[k])
					push_result(rtsp_pkg::ST_DESTROYED, 6'(gone[k]), k == gone.size() - 1);
			end
			default: push_result(rtsp_pkg::ST_BAD, '0, 1'b1);
		endcase
	endtask

	// Driver: presents queued requests, idling at random. A new request is
	// presented only once the previous one was taken at the last rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_requests.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_result(input rtsp_pkg::result_t got);
		rtsp_pkg::result_t e;
		results_seen++;
		// The model runs at the acceptance edge of a request, ahead of any
		// result that the request can cause.
		if (expected_results.size() == 0) begin
			$error("unexpected result status %0d slot %0d", got.status, got.slot);
			errors++;
			return;
		end
		e = expected_results.pop_front();
		if (got.status !== e.status) begin
			$error("status expected %0d actual %0d", e.status, got.status); errors++;
		end
		if (got.slot !== e.slot) begin
			$error("slot expected %0d actual %0d", e.slot, got.slot); errors++;
		end
		if (got.live_count !== e.live_count) begin
			$error("live_count expected %0d actual %0d", e.live_count, got.live_count);
			errors++;
		end
		if (got.last !== e.last) begin
			$error("last expected %0d actual %0d", e.last, got.last); errors++;
		end
	endtask

	// Monitor: predicts each accepted request, then checks each output transfer.
	rtsp_pkg::result_t mon_item;
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		idle_cycles <= ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			? 0 : idle_cycles + 1;
		if (arst_n && s_axis_tvalid && s_axis_tready) predict_pool_step(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) begin
			mon_item.status = m_axis_tdata[2:0];
			mon_item.slot = m_axis_tdata[8:3];
			mon_item.live_count = m_axis_tdata[15:9];
			mon_item.last = m_axis_tlast;
			check_result(mon_item);
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [87:0] make_acquire(input logic knd, input logic [30:0] fmt,
			input logic [15:0] cp, input logic [15:0] w, input logic [15:0] h);
		return {6'd0, h, w, cp, fmt, knd, rtsp_pkg::ACT_ACQUIRE};
	endfunction

	function automatic logic [87:0] make_release(input logic [5:0] t);
		return {t, 80'd0, rtsp_pkg::ACT_RELEASE};
	endfunction

	function automatic logic [87:0] make_flush();
		return {86'd0, rtsp_pkg::ACT_FLUSH};
	endfunction

	// Waits for the pool to drain, then lets the core finish any tail work.
	task automatic drain();
		while (pending_requests.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (2 * NSLOT + 20) @(posedge clk);
	endtask

	task automatic write_default_caps(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pm_default_caps = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A random request: acquires most often, from a small descriptor set so that
	// reuse, release and aging see real traffic.
	task automatic queue_random(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 45)
				pending_requests.push_back(make_acquire(1'($urandom_range(1)),
					$urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(2)),
					16'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)),
					$urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(2)),
					$urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(2))));
			else if (r < 80)
				pending_requests.push_back(make_release(6'($urandom_range(r < 75 ? 7 : 63))));
			else if (r < 96)
				pending_requests.push_back(make_flush());
			else
				pending_requests.push_back({86'($urandom) | {$urandom, $urandom} << 20, 2'd3});
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		errors = 0;
		results_seen = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pm_empty = '1;
		pm_avail = '0;
		pm_default_caps = '0;
		for (int i = 0; i < NSLOT; i++) begin
			pm_age[i] = 0;
			pm_desc[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: size errors, extremes, reuse, bad releases, aging.
		write_default_caps(16'hFFFF);
		pending_requests.push_back(make_acquire(0, 5, 0, 0, 4));
		pending_requests.push_back(make_acquire(1, 5, 0, 4, 0));
		pending_requests.push_back(make_acquire(1, 31'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_requests.push_back(make_acquire(0, 0, 0, 1, 1));
		pending_requests.push_back(make_release(0));
		pending_requests.push_back(make_release(0));
		pending_requests.push_back(make_release(63));
		pending_requests.push_back(make_acquire(1, 31'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_requests.push_back(make_release(0));
		pending_requests.push_back(make_release(1));
		pending_requests.push_back(make_flush());
		pending_requests.push_back(make_flush());
		pending_requests.push_back(make_flush());
		pending_requests.push_back(make_flush());
		pending_requests.push_back({86'h3FFFFFFFFFFFFFFFFFFFFF, 2'd3});
		drain();

		// Fill the pool completely, then ask once more for pool full.
		write_default_caps(16'h0000);
		for (int i = 0; i < NSLOT; i++)
			pending_requests.push_back(make_acquire(i[0], 31'(i), 16'h00FF, 16'(i + 1), 16'd7));
		pending_requests.push_back(make_acquire(0, 31'h1234, 0, 3, 3));
		for (int i = 0; i < NSLOT; i++) pending_requests.push_back(make_release(6'(i)));
		repeat (3) pending_requests.push_back(make_flush());
		drain();

		// Random phases with different handshake pressure and settings.
		for (int ph = 0; ph < 4; ph++) begin
			write_default_caps(ph == 3 ? 16'hA5A5 : 16'($urandom));
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 69; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 69; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			queue_random(26);
			drain();
		end

		$display("covered directed corner requests, a full pool and four random phases;");
		$display("%0d results checked across six default_caps settings", results_seen);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/rtsp_pkg.sv
rtl/rtsp_desc_mem.sv
rtl/render_target_slot_pool_core.sv
dv/render_target_slot_pool_core_tb.sv
